@@ rtl/sbsh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsh_pkg: shared types and constants for the SHA-256 byte stream hasher
// Request and digest payload structs, the sequencer-to-datapath control
// bundle, the round constant table and the initial hash values.
// ----------------------------------------------------------------------------
package sbsh_pkg;

    localparam int BlockBytes = 64;
    localparam int Rounds     = 64;
    localparam int HashWords  = 8;
    localparam int WinWords   = 16;

    localparam int FillW  = $clog2(BlockBytes);
    localparam int RoundW = $clog2(Rounds);
    localparam int WordW  = $clog2(HashWords);

    // first pad byte and the block position where the length field starts
    localparam logic [7:0]       PadLead  = 8'h80;
    localparam logic [FillW-1:0] LenStart = FillW'(56);

    // one input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_message;
    } byte_item_t;

    // one digest word
    typedef struct packed {
        logic [31:0]      digest_word;
        logic [WordW-1:0] word_index;
        logic             last_word;
    } digest_item_t;

    // sequencer commands to the datapath
    typedef struct packed {
        logic              shift_en;
        logic [7:0]        shift_byte;
        logic              start;
        logic              round_en;
        logic [RoundW-1:0] rnd;
        logic              fold;
        logic              init;
        logic              emit_load;
        logic [WordW-1:0]  word_sel;
    } core_ctl_t;

    localparam logic [31:0] HashInit [HashWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

@@ rtl/sbsh_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsh_core: SHA-256 round datapath
// Holds the 16-word block window (bytes shift in from the right), the eight
// working variables and the hash state. One round per cycle through a single
// shared round unit; the window doubles as the message schedule.
// ----------------------------------------------------------------------------
module sbsh_core
    import sbsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  core_ctl_t   ctl,
    output logic [31:0] hash_rd
);

    logic [31:0] win_reg  [WinWords];
    logic [31:0] win_next [WinWords];
    logic [31:0] v_reg    [HashWords];
    logic [31:0] v_next   [HashWords];
    logic [31:0] hash_reg [HashWords];
    logic [31:0] hash_next[HashWords];

    logic [31:0] w_cur;
    logic [31:0] t1;
    logic [31:0] t2;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    // schedule word for this round
    always_comb
    begin
        if (ctl.rnd < RoundW'(WinWords))
        begin
            w_cur = win_reg[0];
        end
        else
        begin
            w_cur = (rotr(win_reg[14], 17) ^ rotr(win_reg[14], 19) ^ (win_reg[14] >> 10))
                  + win_reg[9]
                  + (rotr(win_reg[1], 7) ^ rotr(win_reg[1], 18) ^ (win_reg[1] >> 3))
                  + win_reg[0];
        end
    end

    // shared round unit
    always_comb
    begin
        t1 = v_reg[7]
           + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + RoundK[ctl.rnd] + w_cur;
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // window: byte shift while collecting, word shift while compressing
    always_comb
    begin
        win_next = win_reg;
        if (ctl.shift_en)
        begin
            for (int i = 0; i < WinWords - 1; i++)
            begin
                win_next[i] = {win_reg[i][23:0], win_reg[i+1][31:24]};
            end
            win_next[WinWords-1] = {win_reg[WinWords-1][23:0], ctl.shift_byte};
        end
        else if (ctl.round_en)
        begin
            for (int i = 0; i < WinWords - 1; i++)
            begin
                win_next[i] = win_reg[i+1];
            end
            win_next[WinWords-1] = w_cur;
        end
    end

    // working variables
    always_comb
    begin
        v_next = v_reg;
        if (ctl.start)
        begin
            v_next = hash_reg;
        end
        else if (ctl.round_en)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
    end

    // hash state
    always_comb
    begin
        hash_next = hash_reg;
        if (ctl.init)
        begin
            hash_next = HashInit;
        end
        else if (ctl.fold)
        begin
            for (int i = 0; i < HashWords; i++)
            begin
                hash_next[i] = hash_reg[i] + v_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        v_reg   <= v_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= HashInit;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

    assign hash_rd = hash_reg[ctl.word_sel];

endmodule

@@ rtl/sbsh_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsh_seq: request intake, padding and round sequencer
// Counts bytes and message bits, feeds pad bytes into the block window,
// steps the 64 rounds and the hash fold, then walks out the digest words.
// ----------------------------------------------------------------------------
module sbsh_seq
    import sbsh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  byte_item_t byte_data,
    input  logic       out_busy,
    output core_ctl_t  ctl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [FillW-1:0]   fill_reg, fill_next;
    logic [63:0]        len_reg, len_next;
    logic [RoundW-1:0]  rnd_reg, rnd_next;
    logic [WordW-1:0]   wcnt_reg, wcnt_next;
    logic               pad_reg, pad_next;
    logic               first_reg, first_next;
    logic               lenok_reg, lenok_next;

    logic [7:0]         pad_byte;
    logic               block_full;

    assign block_full = (fill_reg == FillW'(BlockBytes - 1));

    // pad byte for the current position: lead marker, zeros, then length
    always_comb
    begin
        if (first_reg)
        begin
            pad_byte = PadLead;
        end
        else if (lenok_reg && (fill_reg >= LenStart))
        begin
            pad_byte = len_reg[{~fill_reg[2:0], 3'b000} +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        rnd_next   = rnd_reg;
        wcnt_next  = wcnt_reg;
        pad_next   = pad_reg;
        first_next = first_reg;
        lenok_next = lenok_reg;
        ctl        = '0;
        ctl.rnd      = rnd_reg;
        ctl.word_sel = wcnt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (byte_valid)
                begin
                    if (byte_data.end_message)
                    begin
                        pad_next   = 1'b1;
                        first_next = 1'b1;
                        lenok_next = 1'b0;
                        state_next = ST_PAD;
                    end
                    if (byte_data.byte_present)
                    begin
                        ctl.shift_en   = 1'b1;
                        ctl.shift_byte = byte_data.data_byte;
                        fill_next      = fill_reg + 1'b1;
                        len_next       = len_reg + 64'd8;
                        if (block_full)
                        begin
                            ctl.start  = 1'b1;
                            rnd_next   = '0;
                            pad_next   = byte_data.end_message;
                            state_next = ST_COMP;
                        end
                    end
                end
            end

            ST_COMP:
            begin
                ctl.round_en = 1'b1;
                rnd_next     = rnd_reg + 1'b1;
                if (rnd_reg == RoundW'(Rounds - 1))
                begin
                    state_next = ST_FOLD;
                end
            end

            ST_FOLD:
            begin
                ctl.fold = 1'b1;
                if (!pad_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!first_reg && lenok_reg)
                begin
                    wcnt_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    // marker pending or in previous block: length block follows
                    if (!first_reg)
                    begin
                        lenok_next = 1'b1;
                    end
                    state_next = ST_PAD;
                end
            end

            ST_PAD:
            begin
                ctl.shift_en   = 1'b1;
                ctl.shift_byte = pad_byte;
                fill_next      = fill_reg + 1'b1;
                if (first_reg)
                begin
                    first_next = 1'b0;
                    lenok_next = (fill_reg < LenStart);
                end
                if (block_full)
                begin
                    ctl.start  = 1'b1;
                    rnd_next   = '0;
                    state_next = ST_COMP;
                end
            end

            ST_EMIT:
            begin
                if (!out_busy)
                begin
                    ctl.emit_load = 1'b1;
                    wcnt_next     = wcnt_reg + 1'b1;
                    if (wcnt_reg == WordW'(HashWords - 1))
                    begin
                        ctl.init   = 1'b1;
                        len_next   = '0;
                        pad_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            len_reg   <= '0;
            rnd_reg   <= '0;
            wcnt_reg  <= '0;
            pad_reg   <= 1'b0;
            first_reg <= 1'b0;
            lenok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            rnd_reg   <= rnd_next;
            wcnt_reg  <= wcnt_next;
            pad_reg   <= pad_next;
            first_reg <= first_next;
            lenok_reg <= lenok_next;
        end
    end

    assign byte_stall = (state_reg != ST_IDLE);

endmodule

@@ rtl/sha256_byte_stream_hasher.sv @@
`timescale 1ns / 1ps
// Intake: one byte request per cycle while a block fills; the 64th byte of a
//   block starts the 64 rounds on the shared round unit plus hash fold.
// End of message: pad bytes one per cycle to the block end, a compression
//   (and another pad block if the length spills over), then eight digest words,
//   one per cycle unless the receiver stalls. Reset: hash state to the SHA-256
//   initial values, bit and byte counts to zero; the window needs no clearing.
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher: SHA-256 over a byte stream
// Sequencer plus round datapath; digest words leave through an output register
// so the next message can start while the last word waits.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher
    import sbsh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    output logic         byte_stall,
    input  byte_item_t   byte_data,
    output logic         digest_valid,
    input  logic         digest_stall,
    output digest_item_t digest_data
);

    core_ctl_t    ctl;
    logic [31:0]  hash_rd;
    logic         out_busy;
    logic         out_valid_reg;
    digest_item_t out_data_reg;

    sbsh_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .out_busy   (out_busy),
        .ctl        (ctl)
    );

    sbsh_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .hash_rd (hash_rd)
    );

    assign out_busy = out_valid_reg && digest_stall;

    // digest output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!digest_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit_load)
        begin
            out_data_reg.digest_word <= hash_rd;
            out_data_reg.word_index  <= ctl.word_sel;
            out_data_reg.last_word   <= (ctl.word_sel == WordW'(HashWords - 1));
        end
    end

    assign digest_valid = out_valid_reg;
    assign digest_data  = out_data_reg;

endmodule

@@ rtl/sbsh_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsh_checker: port-level checks for the SHA-256 byte stream hasher
// Watches the request and digest channels; bound to the top level.
// ----------------------------------------------------------------------------
module sbsh_checker
    import sbsh_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         byte_valid,
    input logic         byte_stall,
    input logic         digest_valid,
    input logic         digest_stall,
    input digest_item_t digest_data
);

    // a held digest word does not change
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_stall |=> digest_valid && $stable(digest_data))
        else $error("digest word changed while stalled");

    // last flag marks exactly the final word
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (digest_data.last_word ==
                          (digest_data.word_index == WordW'(HashWords - 1))))
        else $error("last_word does not match word_index");

    // a digest always starts with word zero
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(digest_valid) |-> (digest_data.word_index == '0))
        else $error("digest did not start at word zero");

    // words of one digest follow without a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_stall && !digest_data.last_word |=> digest_valid)
        else $error("gap inside a digest");

    // no new request is taken while a digest is still being sent
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_data.last_word |-> !(byte_valid && !byte_stall))
        else $error("request taken during digest output");

endmodule

bind sha256_byte_stream_hasher sbsh_checker u_sbsh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest_data  (digest_data)
);

@@ dv/tb_sha256_byte_stream_hasher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha256_byte_stream_hasher: self-checking bench for the SHA-256 hasher
// Drives byte requests: first a directed table, then random messages, some with
// lengths near the padding boundaries. A behavioral SHA-256 predicts each
// digest. Digest words are checked field by field. Both sides idle at random,
// and the receiver holds off once for a long stretch to back up the input.
// ----------------------------------------------------------------------------
module tb_sha256_byte_stream_hasher;
    import sbsh_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int LongHold   = 600;
    localparam int DrainWait  = 150;
    localparam int RandItems  = 95;
    localparam int DirRows    = 13;

    typedef logic [255:0] digest_t;

    // one stimulus row; known marks a digest typed in by hand
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_message;
        logic       known;
        digest_t    digest;
    } stim_row_t;

    typedef enum logic [1:0] {FLOW_FREE, FLOW_RANDOM, FLOW_PERIODIC} flow_mode_t;

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         byte_valid   = 1'b0;
    logic         byte_stall;
    byte_item_t   byte_data    = '0;
    logic         digest_valid;
    logic         digest_stall = 1'b0;
    digest_item_t digest_data;

    sha256_byte_stream_hasher dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_data  (digest_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // SHA-256 predictor
    // ------------------------------------------------------------------
    logic [31:0]  sha_state [HashWords];
    logic [63:0]  sha_bits;
    logic [7:0]   sha_block [BlockBytes];
    digest_item_t digest_words_due [$];

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void sha_compress();
        logic [31:0] w [Rounds];
        logic [31:0] v [HashWords];
        logic [31:0] s0, s1, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {sha_block[4*i], sha_block[4*i+1], sha_block[4*i+2], sha_block[4*i+3]};
        for (int i = 16; i < Rounds; i++)
        begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        for (int i = 0; i < HashWords; i++)
            v[i] = sha_state[i];
        for (int i = 0; i < Rounds; i++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < HashWords; i++)
            sha_state[i] = sha_state[i] + v[i];
    endfunction

    function automatic void sha_restart();
        for (int i = 0; i < HashWords; i++)
            sha_state[i] = HashInit[i];
        sha_bits = '0;
    endfunction

    // absorb one request; returns 1 with the digest when the message ends
    function automatic bit sha_take_request(input byte_item_t req, output digest_t digest);
        int          pos;
        logic [63:0] msg_bits;
        digest = '0;
        if (req.byte_present)
        begin
            pos = int'(sha_bits[8:3]);
            sha_block[pos] = req.data_byte;
            sha_bits = sha_bits + 64'd8;
            if (pos == BlockBytes - 1)
                sha_compress();
        end
        if (!req.end_message)
            return 1'b0;

        // pad: lead byte, zeros, then the big-endian bit count
        msg_bits = sha_bits;
        pos = int'(msg_bits[8:3]);
        sha_block[pos] = PadLead;
        pos++;
        if (pos > int'(LenStart))
        begin
            while (pos < BlockBytes)
            begin
                sha_block[pos] = 8'h00;
                pos++;
            end
            sha_compress();
            pos = 0;
        end
        while (pos < int'(LenStart))
        begin
            sha_block[pos] = 8'h00;
            pos++;
        end
        for (int i = 0; i < 8; i++)
            sha_block[int'(LenStart) + i] = msg_bits[63 - 8*i -: 8];
        sha_compress();

        for (int i = 0; i < HashWords; i++)
            digest[255 - 32*i -: 32] = sha_state[i];
        sha_restart();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus schedule
    // ------------------------------------------------------------------
    stim_row_t stim_q [$];
    stim_row_t dir_table [DirRows];

    function automatic void push_req(input logic [7:0] data, input logic present,
                                     input logic last);
        stim_row_t row;
        row = '0;
        row.data_byte    = data;
        row.byte_present = present;
        row.end_message  = last;
        stim_q.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts with random gaps; prediction runs on acceptance
    // ------------------------------------------------------------------
    int        next_row;
    int        held_row;
    int        burst_left;
    int        gap_left;
    bit        took_req;
    bit        has_digest;
    digest_t   predicted;
    byte_item_t req_now;
    digest_item_t word_due;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_data  <= '0;
            next_row   = 0;
            held_row   = 0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            took_req = byte_valid && !byte_stall;
            if (took_req)
            begin
                req_now.data_byte    = stim_q[held_row].data_byte;
                req_now.byte_present = stim_q[held_row].byte_present;
                req_now.end_message  = stim_q[held_row].end_message;
                has_digest = sha_take_request(req_now, predicted);
                if (has_digest)
                begin
                    if (stim_q[held_row].known)
                        predicted = stim_q[held_row].digest;
                    for (int i = 0; i < HashWords; i++)
                    begin
                        word_due.digest_word = predicted[255 - 32*i -: 32];
                        word_due.word_index  = WordW'(i);
                        word_due.last_word   = (i == HashWords - 1);
                        digest_words_due.push_back(word_due);
                    end
                end
            end

            // offer the next request once the current one is gone
            if (!byte_valid || took_req)
            begin
                if (gap_left > 0)
                begin
                    byte_valid <= 1'b0;
                    gap_left--;
                end
                else if (next_row < stim_q.size())
                begin
                    byte_valid <= 1'b1;
                    byte_data  <= '{data_byte:    stim_q[next_row].data_byte,
                                    byte_present: stim_q[next_row].byte_present,
                                    end_message:  stim_q[next_row].end_message};
                    held_row = next_row;
                    next_row++;
                    if (burst_left > 0)
                        burst_left--;
                    else if ($urandom_range(0, 4) == 0)
                    begin
                        // a long stretch with no idling
                        burst_left = $urandom_range(30, 80);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 10);
                        gap_left   = $urandom_range(1, 6);
                    end
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: checks each digest word, stalls on its own pattern
    // ------------------------------------------------------------------
    int           fail_count;
    int           words_seen;
    int           hold_left;
    bit           held_once;
    int           seg_left;
    flow_mode_t   flow_mode;
    digest_item_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digest_stall <= 1'b0;
            fail_count = 0;
            words_seen = 0;
            hold_left  = 0;
            held_once  = 1'b0;
            seg_left   = 0;
            flow_mode  = FLOW_FREE;
        end
        else
        begin
            if (digest_valid && !digest_stall)
            begin
                words_seen++;
                if (digest_words_due.size() == 0)
                begin
                    $error("unexpected digest word %h index %0d", digest_data.digest_word,
                           digest_data.word_index);
                    fail_count++;
                end
                else
                begin
                    want = digest_words_due.pop_front();
                    if (digest_data.digest_word !== want.digest_word)
                    begin
                        $error("digest_word: expected %h, got %h", want.digest_word,
                               digest_data.digest_word);
                        fail_count++;
                    end
                    if (digest_data.word_index !== want.word_index)
                    begin
                        $error("word_index: expected %0d, got %0d", want.word_index,
                               digest_data.word_index);
                        fail_count++;
                    end
                    if (digest_data.last_word !== want.last_word)
                    begin
                        $error("last_word: expected %0d, got %0d", want.last_word,
                               digest_data.last_word);
                        fail_count++;
                    end
                end
            end

            // one long hold-off so the block backs up into its input
            if (hold_left > 0)
            begin
                digest_stall <= 1'b1;
                hold_left--;
            end
            else if (!held_once && words_seen >= 2 * HashWords)
            begin
                held_once = 1'b1;
                hold_left = LongHold;
                digest_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    flow_mode = flow_mode_t'($urandom_range(0, 2));
                    seg_left  = $urandom_range(5, 40);
                end
                else
                    seg_left--;
                case (flow_mode)
                    FLOW_FREE:     digest_stall <= 1'b0;
                    FLOW_RANDOM:   digest_stall <= 1'($urandom_range(0, 1));
                    default:       digest_stall <= (seg_left % 3 == 0);
                endcase
            end
        end
    end

    // watchdog
    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int msg_len;
        int rand_items;
        int rand_msgs;
        bit split_end;

        sha_restart();
        for (int i = 0; i < BlockBytes; i++)
            sha_block[i] = 8'h00;

        // directed: no-op, empty message, "abc", extremes, empty final request
        dir_table = '{
            '{8'h00, 1'b0, 1'b0, 1'b0, 256'h0},
            '{8'hff, 1'b0, 1'b1, 1'b1,
              256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855},
            '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
            '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
            '{8'haa, 1'b0, 1'b0, 1'b0, 256'h0},
            '{8'h63, 1'b1, 1'b1, 1'b1,
              256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad},
            '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
            '{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
            '{8'h55, 1'b0, 1'b1, 1'b0, 256'h0},
            '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
            '{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
            '{8'h80, 1'b1, 1'b0, 1'b0, 256'h0},
            '{8'h7f, 1'b1, 1'b1, 1'b0, 256'h0}
        };
        for (int i = 0; i < DirRows; i++)
            stim_q.push_back(dir_table[i]);

        // random messages; the first and about one in eight of the rest sit
        // near a block boundary so padding may spill into a second block
        rand_items = 0;
        rand_msgs  = 0;
        while (rand_items < RandItems || rand_msgs < 8)
        begin
            if (rand_msgs == 0 || $urandom_range(0, 7) == 0)
                msg_len = $urandom_range(55, 65);
            else
                msg_len = $urandom_range(0, 12);
            split_end = (msg_len == 0) || ($urandom_range(0, 3) == 0);
            for (int b = 0; b < msg_len; b++)
            begin
                if ($urandom_range(0, 7) == 0)
                    push_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                push_req(8'($urandom_range(0, 255)), 1'b1,
                         !split_end && (b == msg_len - 1));
                rand_items++;
            end
            if (split_end)
            begin
                push_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                rand_items++;
            end
            rand_msgs++;
        end

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // wait for every request to go in and every digest word to come out
        @(negedge clk);
        while (next_row < stim_q.size() || byte_valid || digest_words_due.size() != 0)
            @(negedge clk);
        repeat (DrainWait) @(negedge clk);

        if (fail_count == 0 && digest_words_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
